// ===== rtl/npr_pkg.sv =====
// Package for the next-PC resolver: item and result types, opcode constants,
// status codes and the condition test used by decode.
// No dependencies.
package npr_pkg;

  // Longest instruction still decoded as a control transfer.
  localparam int unsigned MAX_TRANSFER_LENGTH = 7;

  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 40;

  // Primary opcodes.
  localparam logic [7:0] OP_CALL_REL32 = 8'he8;
  localparam logic [7:0] OP_JMP_REL32  = 8'he9;
  localparam logic [7:0] OP_JMP_REL8   = 8'heb;
  localparam logic [7:0] OP_GRP5       = 8'hff;
  localparam logic [7:0] OP_TWO_BYTE   = 8'h0f;
  localparam logic [7:0] OP_RET_NEAR   = 8'hc3;
  localparam logic [7:0] OP_JECXZ      = 8'he3;
  localparam logic [7:0] OP_CALL_FAR   = 8'h9a;
  localparam logic [7:0] OP_JMP_FAR    = 8'hea;
  localparam logic [7:0] OP_RET_FAR    = 8'hcb;
  localparam logic [7:0] OP_RET_IMM    = 8'hc2;
  localparam logic [7:0] OP_RETF_IMM   = 8'hca;
  localparam logic [7:0] OP_INT3       = 8'hcc;
  localparam logic [7:0] OP_INT_IMM    = 8'hcd;
  localparam logic [7:0] OP_INTO       = 8'hce;
  localparam logic [7:0] OP_IRET       = 8'hcf;
  localparam logic [7:0] OP_LOOPNE     = 8'he0;
  localparam logic [7:0] OP_LOOPE      = 8'he1;
  localparam logic [7:0] OP_LOOP       = 8'he2;

  // High nibbles of the short and near conditional jumps.
  localparam logic [3:0] JCC_SHORT_HI = 4'h7;
  localparam logic [3:0] JCC_NEAR_HI  = 4'h8;

  // Reg field of the ff group.
  localparam logic [2:0] GRP5_CALL_NEAR = 3'd2;
  localparam logic [2:0] GRP5_CALL_FAR  = 3'd3;
  localparam logic [2:0] GRP5_JMP_NEAR  = 3'd4;
  localparam logic [2:0] GRP5_JMP_FAR   = 3'd5;

  // Lengths fixed by the encoding.
  localparam logic [3:0] LEN_REL8       = 4'd2;
  localparam logic [3:0] LEN_REL32      = 4'd5;
  localparam logic [3:0] LEN_JCC_REL32  = 4'd6;
  localparam logic [3:0] LEN_MODRM_MIN  = 4'd2;
  localparam logic [3:0] LEN_CALL_IND_MAX = 4'd6;
  localparam logic [3:0] LEN_JMP_IND_MAX  = 4'd7;

  // Condition groups, bits 3:1 of the condition code.
  localparam logic [2:0] CC_O  = 3'd0;
  localparam logic [2:0] CC_B  = 3'd1;
  localparam logic [2:0] CC_Z  = 3'd2;
  localparam logic [2:0] CC_BE = 3'd3;
  localparam logic [2:0] CC_S  = 3'd4;
  localparam logic [2:0] CC_P  = 3'd5;
  localparam logic [2:0] CC_L  = 3'd6;
  localparam logic [2:0] CC_LE = 3'd7;

  // Flag positions.
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 2;
  localparam int unsigned FLAG_ZF = 6;
  localparam int unsigned FLAG_SF = 7;
  localparam int unsigned FLAG_OF = 11;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_BAD_LENGTH  = 2'd2
  } npr_status_t;

  // Request held in the input register; seq_address is address plus length.
  typedef struct packed {
    logic [31:0] seq_address;
    logic [3:0]  insn_length;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [7:0]  byte_four;
    logic [7:0]  byte_five;
    logic [11:0] flag_bits;
    logic [31:0] stack_top_word;
    logic [31:0] indirect_target;
  } npr_item_t;

  typedef struct packed {
    npr_status_t status;
    logic        is_call;
    logic [31:0] next_address;
  } npr_result_t;

  function automatic logic cond_holds(input logic [3:0] cc, input logic [11:0] fl);
    logic t;
    t = 1'b0;
    unique case (cc[3:1])
      CC_O:  t = fl[FLAG_OF];
      CC_B:  t = fl[FLAG_CF];
      CC_Z:  t = fl[FLAG_ZF];
      CC_BE: t = fl[FLAG_CF] | fl[FLAG_ZF];
      CC_S:  t = fl[FLAG_SF];
      CC_P:  t = fl[FLAG_PF];
      CC_L:  t = fl[FLAG_SF] ^ fl[FLAG_OF];
      CC_LE: t = (fl[FLAG_SF] ^ fl[FLAG_OF]) | fl[FLAG_ZF];
      default: t = 1'b0;
    endcase
    return cc[0] ? ~t : t;
  endfunction

endpackage

// ===== rtl/npr_decode.sv =====
// Opcode decode and branch target add for one registered request.
// Depends on npr_pkg (item/result types, opcodes, condition test).
module npr_decode (
  input  npr_pkg::npr_item_t   item,
  output npr_pkg::npr_result_t result
);

  logic [31:0]         rel32_a;    // displacement after a one-byte opcode
  logic [31:0]         rel32_b;    // displacement after 0f 8x
  logic [31:0]         rel8;
  logic [31:0]         offset;
  logic                take_rel;
  logic                take_stack;
  logic                take_ind;
  logic                call;
  npr_pkg::npr_status_t st;
  logic [3:0]          len;
  logic [31:0]         target;

  assign len     = item.insn_length;
  assign rel32_a = {item.byte_four, item.byte_three, item.byte_two, item.byte_one};
  assign rel32_b = {item.byte_five, item.byte_four, item.byte_three, item.byte_two};
  assign rel8    = {{24{item.byte_one[7]}}, item.byte_one};

  always_comb begin
    offset     = rel32_a;
    take_rel   = 1'b0;
    take_stack = 1'b0;
    take_ind   = 1'b0;
    call       = 1'b0;
    st         = npr_pkg::ST_OK;
    if (len <= 4'(npr_pkg::MAX_TRANSFER_LENGTH)) begin
      unique case (item.byte_zero)
        npr_pkg::OP_CALL_REL32: begin
          if (len != npr_pkg::LEN_REL32) st = npr_pkg::ST_BAD_LENGTH;
          else begin
            call     = 1'b1;
            take_rel = 1'b1;
          end
        end
        npr_pkg::OP_JMP_REL32: begin
          if (len != npr_pkg::LEN_REL32) st = npr_pkg::ST_BAD_LENGTH;
          else take_rel = 1'b1;
        end
        npr_pkg::OP_JMP_REL8: begin
          offset = rel8;
          if (len != npr_pkg::LEN_REL8) st = npr_pkg::ST_BAD_LENGTH;
          else take_rel = 1'b1;
        end
        npr_pkg::OP_GRP5: begin
          unique case (item.byte_one[5:3])
            npr_pkg::GRP5_CALL_NEAR: begin
              if (len < npr_pkg::LEN_MODRM_MIN || len > npr_pkg::LEN_CALL_IND_MAX)
                st = npr_pkg::ST_BAD_LENGTH;
              else begin
                call     = 1'b1;
                take_ind = 1'b1;
              end
            end
            npr_pkg::GRP5_JMP_NEAR: begin
              if (len < npr_pkg::LEN_MODRM_MIN || len > npr_pkg::LEN_JMP_IND_MAX)
                st = npr_pkg::ST_BAD_LENGTH;
              else take_ind = 1'b1;
            end
            npr_pkg::GRP5_CALL_FAR, npr_pkg::GRP5_JMP_FAR: st = npr_pkg::ST_UNSUPPORTED;
            default: ;
          endcase
        end
        npr_pkg::OP_TWO_BYTE: begin
          offset = rel32_b;
          if (item.byte_one[7:4] == npr_pkg::JCC_NEAR_HI) begin
            if (len != npr_pkg::LEN_JCC_REL32) st = npr_pkg::ST_BAD_LENGTH;
            else take_rel = npr_pkg::cond_holds(item.byte_one[3:0], item.flag_bits);
          end
        end
        npr_pkg::OP_RET_NEAR: take_stack = 1'b1;
        npr_pkg::OP_JECXZ: begin
          st = (len != npr_pkg::LEN_REL8) ? npr_pkg::ST_BAD_LENGTH
                                          : npr_pkg::ST_UNSUPPORTED;
        end
        npr_pkg::OP_CALL_FAR, npr_pkg::OP_JMP_FAR, npr_pkg::OP_RET_FAR,
        npr_pkg::OP_RET_IMM, npr_pkg::OP_RETF_IMM, npr_pkg::OP_INT3,
        npr_pkg::OP_INT_IMM, npr_pkg::OP_INTO, npr_pkg::OP_IRET,
        npr_pkg::OP_LOOPNE, npr_pkg::OP_LOOPE, npr_pkg::OP_LOOP:
          st = npr_pkg::ST_UNSUPPORTED;
        default: begin
          offset = rel8;
          if (item.byte_zero[7:4] == npr_pkg::JCC_SHORT_HI) begin
            if (len != npr_pkg::LEN_REL8) st = npr_pkg::ST_BAD_LENGTH;
            else take_rel = npr_pkg::cond_holds(item.byte_zero[3:0], item.flag_bits);
          end
        end
      endcase
    end
  end

  // Single target adder shared by every relative form.
  assign target = item.seq_address + offset;

  always_comb begin
    result.status       = st;
    result.is_call      = 1'b0;
    result.next_address = item.seq_address;
    if (st == npr_pkg::ST_OK) begin
      result.is_call = call;
      if (take_rel)        result.next_address = target;
      else if (take_stack) result.next_address = item.stack_top_word;
      else if (take_ind)   result.next_address = item.indirect_target;
    end
  end

endmodule

// ===== rtl/x86_next_pc_resolver_unit.sv =====
// Top level of the x86 next-PC resolver: input register, decode, result register.
// Depends on npr_pkg and npr_decode.
//
//  channel  | direction | width | contents
//  ---------+-----------+-------+------------------------------------------------
//  s_axis   | in        | 160   | instruction request (address, length, bytes,
//           |           |       | flags, stack top word, indirect target)
//  m_axis   | out       |  40   | next address, call mark, status
//
// Stages: a request passes through the input register (which captures address
// plus length, formed on the way in), then through decode and the target adder
// into the result register. One request per cycle while the output is not stalled.
// Reset: rst clears both stage valid bits; payload registers are not reset.
// Stalls: ready propagates back through both stages, so a stalled output
// still lets the input register fill before s_axis_tready drops.
module x86_next_pc_resolver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] insn_address, [35:32] insn_length, [43:36] byte_zero,
  // [51:44] byte_one, [59:52] byte_two, [67:60] byte_three,
  // [75:68] byte_four, [83:76] byte_five, [95:84] flag_bits,
  // [127:96] stack_top_word, [159:128] indirect_target
  input  logic [159:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] next_address, [32] is_call, [34:33] status, [39:35] zero
  output logic [39:0] m_axis_tdata
);

  logic                 in_valid;
  npr_pkg::npr_item_t   in_item;
  npr_pkg::npr_item_t   in_item_next;
  logic                 out_valid;
  npr_pkg::npr_result_t out_result;
  npr_pkg::npr_result_t dec_result;
  logic                 out_ready;
  logic                 in_ready;

  // Advance each stage when its successor can take the request.
  assign out_ready     = !out_valid || m_axis_tready;
  assign in_ready      = !in_valid || out_ready;
  assign s_axis_tready = in_ready;

  // Unpack the request and form the fall-through address on the way in.
  always_comb begin
    in_item_next.seq_address     = s_axis_tdata[31:0] + {28'd0, s_axis_tdata[35:32]};
    in_item_next.insn_length     = s_axis_tdata[35:32];
    in_item_next.byte_zero       = s_axis_tdata[43:36];
    in_item_next.byte_one        = s_axis_tdata[51:44];
    in_item_next.byte_two        = s_axis_tdata[59:52];
    in_item_next.byte_three      = s_axis_tdata[67:60];
    in_item_next.byte_four       = s_axis_tdata[75:68];
    in_item_next.byte_five       = s_axis_tdata[83:76];
    in_item_next.flag_bits       = s_axis_tdata[95:84];
    in_item_next.stack_top_word  = s_axis_tdata[127:96];
    in_item_next.indirect_target = s_axis_tdata[159:128];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Capture payload only on acceptance.
  always_ff @(posedge clk) begin
    if (in_ready && s_axis_tvalid) begin
      in_item <= in_item_next;
    end
  end

  npr_decode u_decode (
    .item   (in_item),
    .result (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_result <= dec_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_result.status, out_result.is_call,
                          out_result.next_address};

  a_status_legal : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.status == npr_pkg::ST_OK ||
                   out_result.status == npr_pkg::ST_UNSUPPORTED ||
                   out_result.status == npr_pkg::ST_BAD_LENGTH))
    else $error("result status out of range");

  a_call_resolved : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.is_call) |-> (out_result.status == npr_pkg::ST_OK))
    else $error("call mark on an unresolved request");

  a_advance : assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_ready) |=> out_valid)
    else $error("request lost between input and result register");

  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled while a stage was free");

endmodule
